// ===== hdl/gds_pkg.sv =====
// gds_pkg: shared types, codes and calendar helpers for the date serial unit
// no dependencies; imported by gregorian_date_serial_unit

package gds_pkg;

  localparam int unsigned FIRST_YEAR = 2000;
  localparam int unsigned LAST_YEAR  = 3999;

  localparam logic [22:0] EPOCH_RESET = 23'd36525;

  // days from 1 jan 2000 up to 1 jan 4000
  localparam logic [19:0] DAYS_IN_RANGE = 20'd730485;

  // floor(x / 365) = (x * RECIP_365) >> RECIP_365_SHIFT for x below 2^20
  localparam logic [19:0] RECIP_365       = 20'd735440;
  localparam int unsigned RECIP_365_SHIFT = 28;

  localparam logic [1:0] FUNC_TO_SERIAL  = 2'd0;
  localparam logic [1:0] FUNC_TO_DATE    = 2'd1;
  localparam logic [1:0] FUNC_ADD_MONTHS = 2'd2;
  localparam logic [1:0] FUNC_ADD_YEARS  = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DATE  = 2'd1;
  localparam logic [1:0] ERR_EARLY = 2'd2;
  localparam logic [1:0] ERR_LATE  = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [23:0]        serial;
    logic signed [11:0] delta;
  } gds_in_t;

  typedef struct packed {
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [23:0] out_serial;
    logic [1:0]  error;
  } gds_out_t;

  // reciprocal divide by 100, exact for x below 43690
  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(13'd5243);
    return p[26:19];
  endfunction

  function automatic logic is_leap(input logic [12:0] y);
    logic [7:0]  q;
    logic [12:0] r;
    q = div100({1'b0, y});
    r = y - 13'(q) * 13'd100;
    return (y[1:0] == 2'b00) && ((r != 13'd0) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd1:    n = 5'd31;
      4'd2:    n = 5'd28;
      4'd3:    n = 5'd31;
      4'd4:    n = 5'd30;
      4'd5:    n = 5'd31;
      4'd6:    n = 5'd30;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd31;
      4'd9:    n = 5'd30;
      4'd10:   n = 5'd31;
      4'd11:   n = 5'd30;
      4'd12:   n = 5'd31;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // day of year at which month m starts, common year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] days_in(input logic [12:0] y, input logic [3:0] m);
    logic [4:0] n;
    n = month_len(m);
    if (m == 4'd2 && is_leap(y)) begin
      n = n + 5'd1;
    end
    return n;
  endfunction

  // days from 1 jan 2000 to 1 jan of year 2000 + yo
  function automatic logic [19:0] year_base(input logic [10:0] yo);
    logic [11:0] y4;
    logic [7:0]  c1;
    logic [7:0]  c4;
    y4 = (12'(yo) + 12'd399) >> 2;
    c1 = div100(14'(yo) + 14'd99);
    c4 = div100(14'(y4));
    return 20'(yo) * 20'd365 + 20'((12'(yo) + 12'd3) >> 2) - 20'(c1) + 20'(c4);
  endfunction

  function automatic logic [1:0] check_date(input logic [12:0] y, input logic [3:0] m,
                                            input logic [4:0] d);
    logic [1:0] e;
    if (m == 4'd0 || m > 4'd12 || d == 5'd0 || d > days_in(y, m)) begin
      e = ERR_DATE;
    end else if (y < 13'(FIRST_YEAR)) begin
      e = ERR_EARLY;
    end else if (y > 13'(LAST_YEAR)) begin
      e = ERR_LATE;
    end else begin
      e = ERR_NONE;
    end
    return e;
  endfunction

endpackage

// ===== hdl/gregorian_date_serial_unit.sv =====
// gregorian_date_serial_unit: date to serial, serial to date, add months, add years
// depends on gds_pkg for payload types, codes and calendar helpers
//
//   channel  signals                      direction  beat taken when
//   in       in_valid_i in_data_i         sink       in_valid_i  & !in_stall_o
//   out      out_valid_o out_data_o       source     out_valid_o & !out_stall_i
//   cfg      cfg_we_i cfg_data_i          sink       cfg_we_i
//
// one beat per cycle sustained while out_stall_i is low; a taken input beat passes the
// input register, two working stage registers and the output register to out_data_o;
// each stage holds while the next one is full and stalled, so bubbles close up
// and the input keeps taking beats while a finished result waits, until all stages fill
// reset clears the stage valid flags and loads off_q with 36525

module gregorian_date_serial_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gds_pkg::gds_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gds_pkg::gds_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [22:0]       cfg_data_i
);

  import gds_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  err;
    logic        at_end;
    logic        neg;
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [19:0] rem;
    logic [10:0] quo;
  } s1_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  err;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [19:0] yb;
    logic        leap;
    logic [10:0] yo;
    logic [8:0]  doy;
    logic [19:0] rem;
  } s2_t;

  logic [22:0] off_q;

  gds_in_t  in_q;
  s1_t      s1_d, s1_q;
  s2_t      s2_d, s2_q;
  gds_out_t out_d, out_q;

  logic v0_q, v1_q, v2_q, v3_q;
  logic en0, en1, en2, en3;

  // stage 1 temporaries
  logic [23:0] rem24;
  logic [39:0] prod365;
  logic [1:0]  err_in;
  logic [16:0] tot;
  logic [28:0] prod3;
  logic [12:0] oy_m;
  logic [16:0] r12;
  logic [13:0] ysum;

  // stage 2 temporaries
  logic [4:0]  last;
  logic [4:0]  od2;
  logic [1:0]  err2;
  logic [19:0] yb0, yb1, yb2;

  // stage 3 temporaries
  logic [11:0] fy;
  logic        leap3;
  logic [8:0]  st;
  logic [8:0]  ost;
  logic [3:0]  om3;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign in_stall_o  = !en0;
  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= EPOCH_RESET;
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        off_q <= cfg_data_i;
      end
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) in_q  <= in_data_i;
    if (en1) s1_q  <= s1_d;
    if (en2) s2_q  <= s2_d;
    if (en3) out_q <= out_d;
  end

  // stage 1: input check, serial offset and first year estimate, month and year moves
  always_comb begin
    s1_d      = '0;
    s1_d.func = in_q.func;

    rem24   = in_q.serial - 24'(off_q) - 24'd1;
    prod365 = 40'(rem24[19:0]) * 40'(RECIP_365);
    err_in  = check_date({1'b0, in_q.year}, in_q.month, in_q.day);

    tot   = 17'(in_q.year) * 17'd12 + 17'(in_q.month) - 17'd1
          + {{5{in_q.delta[11]}}, in_q.delta};
    prod3 = 29'(tot[16:2]) * 29'd10923;
    oy_m  = prod3[27:15];
    r12   = tot - 17'(oy_m) * 17'd12;
    ysum  = 14'(in_q.year) + {{2{in_q.delta[11]}}, in_q.delta};

    s1_d.rem    = rem24[19:0];
    s1_d.quo    = prod365[RECIP_365_SHIFT +: 11];
    s1_d.day    = in_q.day;
    s1_d.at_end = (in_q.day == days_in({1'b0, in_q.year}, in_q.month));

    case (in_q.func)
      FUNC_TO_DATE: begin
        if (in_q.serial <= {1'b0, off_q}) begin
          s1_d.err = ERR_EARLY;
        end else if (rem24 >= 24'(DAYS_IN_RANGE)) begin
          s1_d.err = ERR_LATE;
        end else begin
          s1_d.err = ERR_NONE;
        end
      end
      FUNC_ADD_MONTHS: begin
        s1_d.err   = err_in;
        s1_d.year  = oy_m;
        s1_d.month = 4'(r12) + 4'd1;
      end
      FUNC_ADD_YEARS: begin
        s1_d.err   = err_in;
        s1_d.month = in_q.month;
        // a year below zero sets neg, which stage 2 reports as ERR_LATE; year keeps the low bits of ysum + 296
        s1_d.neg   = ysum[13];
        s1_d.year  = ysum[13] ? 13'(ysum + 14'd296) : ysum[12:0];
      end
      default: begin
        s1_d.err   = err_in;
        s1_d.year  = {1'b0, in_q.year};
        s1_d.month = in_q.month;
      end
    endcase
  end

  // stage 2: result date check and year base; year correction for serial to date
  always_comb begin
    s2_d      = '0;
    s2_d.func = s1_q.func;
    s2_d.rem  = s1_q.rem;

    last = days_in(s1_q.year, s1_q.month);
    if (s1_q.func == FUNC_ADD_MONTHS && (s1_q.at_end || s1_q.day > last)) begin
      od2 = last;
    end else begin
      od2 = s1_q.day;
    end

    if (s1_q.err != ERR_NONE) begin
      err2 = s1_q.err;
    end else if (s1_q.func == FUNC_TO_DATE) begin
      err2 = ERR_NONE;
    end else if (od2 > last) begin
      err2 = ERR_DATE;
    end else if (s1_q.neg) begin
      err2 = ERR_LATE;
    end else if (s1_q.year < 13'(FIRST_YEAR)) begin
      err2 = ERR_EARLY;
    end else if (s1_q.year > 13'(LAST_YEAR)) begin
      err2 = ERR_LATE;
    end else begin
      err2 = ERR_NONE;
    end

    yb0 = year_base(s1_q.quo);
    yb1 = year_base(s1_q.quo - 11'd1);
    yb2 = year_base(s1_q.quo - 11'd2);

    s2_d.err   = err2;
    s2_d.year  = s1_q.year[11:0];
    s2_d.month = s1_q.month;
    s2_d.day   = od2;
    s2_d.leap  = is_leap(s1_q.year);
    s2_d.yb    = year_base(11'(s1_q.year - 13'(FIRST_YEAR)));

    // the estimate from rem / 365 runs at most two years ahead
    if (s1_q.quo != 11'd0 && yb0 > s1_q.rem) begin
      if (s1_q.quo >= 11'd2 && yb1 > s1_q.rem) begin
        s2_d.yo  = s1_q.quo - 11'd2;
        s2_d.doy = 9'(s1_q.rem - yb2);
      end else begin
        s2_d.yo  = s1_q.quo - 11'd1;
        s2_d.doy = 9'(s1_q.rem - yb1);
      end
    end else begin
      s2_d.yo  = s1_q.quo;
      s2_d.doy = 9'(s1_q.rem - yb0);
    end
  end

  // stage 3: month split or serial sum, error zeroing
  always_comb begin
    out_d       = '0;
    out_d.error = s2_q.err;

    fy    = 12'(FIRST_YEAR) + 12'(s2_q.yo);
    leap3 = is_leap({1'b0, fy});
    om3   = 4'd1;
    ost   = 9'd0;
    st    = 9'd0;
    for (int m = 2; m <= 12; m++) begin
      st = month_start(4'(m)) + 9'((m >= 3) && leap3);
      if (s2_q.doy >= st) begin
        om3 = 4'(m);
        ost = st;
      end
    end

    if (s2_q.err == ERR_NONE) begin
      if (s2_q.func == FUNC_TO_DATE) begin
        out_d.out_year   = fy;
        out_d.out_month  = om3;
        out_d.out_day    = 5'(s2_q.doy - ost) + 5'd1;
        out_d.out_serial = 24'(off_q) + 24'(s2_q.rem) + 24'd1;
      end else begin
        out_d.out_year   = s2_q.year;
        out_d.out_month  = s2_q.month;
        out_d.out_day    = s2_q.day;
        out_d.out_serial = 24'(off_q) + 24'(s2_q.yb) + 24'(month_start(s2_q.month))
                         + 24'(s2_q.day) + 24'(s2_q.leap && s2_q.month >= 4'd3);
      end
    end
  end

endmodule
